// ----- sv/icdf_pkg.sv -----
// Package: shared constants, widths and opcodes of the inverse-CDF table sampler.
`default_nettype none
package icdf_pkg;
  localparam int TABLE_DEPTH_DEF   = 4096;
  localparam int FRACTION_BITS_DEF = 32;

  localparam int ID_W   = 13;
  localparam int FRAC_W = 32;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_QUERY = 1'b1;

  localparam logic [ID_W-1:0] SIZE_AT_RESET = 13'd4096;
endpackage
`default_nettype wire

// ----- sv/icdf_if.sv -----
// Interfaces: query/write input channel, result channel and size register write channel.
`default_nettype none
interface icdf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [icdf_pkg::ID_W-1:0]     entry_index;
  logic [icdf_pkg::FRAC_W-1:0]   fraction;
  modport source (output valid, opcode, entry_index, fraction, input ready);
  modport sink   (input valid, opcode, entry_index, fraction, output ready);
endinterface

interface icdf_out_if;
  logic                          valid;
  logic                          ready;
  logic [icdf_pkg::ID_W-1:0]     content_id;
  modport source (output valid, content_id, input ready);
  modport sink   (input valid, content_id, output ready);
endinterface

interface icdf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [icdf_pkg::ID_W-1:0]     table_size;
  modport source (output valid, table_size, input ready);
  modport sink   (input valid, table_size, output ready);
endinterface
`default_nettype wire

// ----- sv/icdf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module icdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- sv/inverse_cdf_table_sampler_top.sv -----
// Inverse-CDF table sampler: the cumulative table lives in one RAM with a registered
// read port. A write transaction stores one entry and gives no result. A query
// transaction runs a lower-bound binary search: one RAM read and compare per cycle,
// at most ceil(log2(size)) steps; the result register is then loaded once the output
// channel can take it. A new transaction is accepted only while idle, that is not
// before the previous query's result is loaded. Entries that a query may touch must
// have been written first; the table is not cleared by reset.
`default_nettype none
module inverse_cdf_table_sampler_top #(
  parameter int TABLE_DEPTH   = icdf_pkg::TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = icdf_pkg::FRACTION_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  icdf_in_if.sink    in_chan,
  icdf_out_if.source out_chan,
  icdf_cfg_if.sink   cfg_chan
);
  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int IdW   = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [icdf_pkg::ID_W-1:0] size_r;
  logic [IdW-1:0]            lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [FRACTION_BITS-1:0]  frac_r;
  logic                      out_valid_r;
  logic [icdf_pkg::ID_W-1:0] out_id_r;

  logic                      in_acc;
  logic [63:0]               frac64;
  logic [FRACTION_BITS-1:0]  frac_in;
  logic [31:0]               idx32, size32, act32;
  logic                      wr_en;
  logic [AddrW-1:0]          wr_addr;
  logic                      rd_en;
  logic [AddrW-1:0]          rd_addr;
  logic [FRACTION_BITS-1:0]  rd_data;
  logic                      ge;
  logic                      out_load;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc         = in_chan.valid && in_chan.ready;

  assign frac64  = 64'(in_chan.fraction);
  assign frac_in = frac64[FRACTION_BITS-1:0];
  assign idx32   = 32'(in_chan.entry_index);
  assign size32  = 32'(size_r);

  always_comb begin
    if (size32 == 32'd0) begin
      act32 = 32'd1;
    end else if (size32 > 32'(TABLE_DEPTH)) begin
      act32 = 32'(TABLE_DEPTH);
    end else begin
      act32 = size32;
    end
  end

  assign wr_en   = in_acc && (in_chan.opcode == icdf_pkg::OP_WRITE) &&
                   (idx32 != 32'd0) && (idx32 <= 32'(TABLE_DEPTH));
  assign wr_addr = AddrW'(idx32 - 32'd1);

  assign ge       = (rd_data >= frac_r);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_chan.opcode == icdf_pkg::OP_QUERY)) begin
          lo_nxt    = IdW'(1);
          hi_nxt    = IdW'(act32);
          state_nxt = (IdW'(1) < IdW'(act32)) ? ST_SRCH : ST_FIN;
        end
      end
      ST_SRCH: begin
        if (ge) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + IdW'(1);
        end
        state_nxt = (lo_nxt < hi_nxt) ? ST_SRCH : ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    mid_nxt = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
  end

  assign rd_en   = (state_nxt == ST_SRCH);
  assign rd_addr = AddrW'(mid_nxt - IdW'(1));

  icdf_ram #(
    .WIDTH (FRACTION_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (frac_in),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= icdf_pkg::SIZE_AT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        size_r <= cfg_chan.table_size;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    if (in_acc) begin
      frac_r <= frac_in;
    end
    if (out_load) begin
      out_id_r <= icdf_pkg::ID_W'(32'(lo_r));
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.content_id = out_id_r;
endmodule
`default_nettype wire
